// ----- rtl/ir2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ir2d_pkg
// Types, constants and digit helpers shared by the radix digit converter.
// ----------------------------------------------------------------------------
package ir2d_pkg;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 7'd97;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd9;
  localparam logic [DIGIT_W-1:0] ALPHA_OFFSET  = 6'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } ir2d_state_t;

  // One digit written into the digit store
  typedef struct packed {
    logic               en;
    logic [DIGIT_W-1:0] digit;
  } ir2d_push_t;

  // Clamp the configured radix into 2..36
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d <= DECIMAL_LIMIT) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_LOWER_A + {1'b0, d - ALPHA_OFFSET};
    end
    return res;
  endfunction

endpackage

// ----- rtl/integer_to_radix_digits_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a non-negative integer into ASCII digits in a configurable radix,
// most significant digit first, with the final digit marked.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------
//   input    | in        | in_valid / in_stall  | value
//   output   | out       | out_valid / out_stall| digit_char, last_digit
//   config   | in        | radix_wr_en          | radix_wr_data
//
// One shared divider finds one digit per division, one quotient bit per cycle;
// decimal 2^31-1 has 10 digits.
// in_stall stays high from the transfer of an item until its last digit sits
// in the output register. Output stalls hold the output register and pause
// digit read-out. Synchronous active-high reset sets radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit import ir2d_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   radix_wr_en,
  input  logic [RADIX_W-1:0]     radix_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit
);

  ir2d_state_t            state;
  ir2d_state_t            state_next;
  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     divisor;
  logic                   in_xfer;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [DIGIT_W-1:0]     remainder;
  logic                   div_done;
  logic                   div_busy;
  logic                   clr;
  ir2d_push_t             push;
  logic                   emit_go;
  logic                   emitting;
  logic                   more;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  assign divisor = eff_radix(radix);
  assign in_xfer = in_valid && !in_stall;
  assign more    = quotient != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done && !more) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emitting) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    div_start  = 1'b0;
    dividend   = quotient;
    clr        = 1'b0;
    push.en    = 1'b0;
    push.digit = remainder;
    emit_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        dividend  = value;
        div_start = in_valid;
        clr       = in_valid;
      end
      ST_DIVIDE: begin
        // Store the digit, then divide the quotient again or start read-out
        if (div_done) begin
          push.en   = 1'b1;
          div_start = more;
          emit_go   = !more;
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  ir2d_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .remainder(remainder),
    .done     (div_done),
    .busy     (div_busy)
  );

  ir2d_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .clr       (clr),
    .push      (push),
    .emit_go   (emit_go),
    .emitting  (emitting),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide phase");

  a_divide_keeps_unit_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (div_busy && state == ST_DIVIDE))
    else $error("accepted item did not start the divider");

endmodule

// ----- rtl/ir2d_div.sv -----
// ----------------------------------------------------------------------------
// ir2d_div
// Restoring shift-subtract divider by a small radix, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ir2d_div import ir2d_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder,
  output logic                   done,
  output logic                   busy
);

  localparam int SW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [SW-1:0]          step;
  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       diff;
  logic                   fits;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == SW'(1));
      if (start) begin
        busy <= 1'b1;
        step <= SW'(VALUE_WIDTH);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == SW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      rem <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, remainder} < {1'b0, divisor}))
    else $error("divider remainder not below divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/ir2d_emit.sv -----
// ----------------------------------------------------------------------------
// ir2d_emit
// Digit store and output stage: collects digits least significant first and
// sends them out most significant first through an output register.
// ----------------------------------------------------------------------------
module ir2d_emit import ir2d_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  ir2d_push_t        push,
  input  logic              emit_go,
  output logic              emitting,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] digit_char,
  output logic              last_digit
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      rd_idx;
  logic               load;
  logic [DIGIT_W-1:0] dig_q;
  logic               last_q;

  assign cnt_m1 = cnt - 1'b1;
  assign rd_idx = cnt_m1[AW-1:0];
  // Load a digit when the output register is empty or its transfer completes
  assign load   = emitting && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      emitting  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clr) begin
        cnt <= '0;
      end else if (push.en) begin
        cnt <= cnt + 1'b1;
      end else if (load) begin
        cnt <= cnt_m1;
      end

      if (emit_go) begin
        emitting <= 1'b1;
      end else if (load && (cnt == CW'(1))) begin
        emitting <= 1'b0;
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      mem[cnt[AW-1:0]] <= push.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_q  <= mem[rd_idx];
      last_q <= (cnt == CW'(1));
    end
  end

  assign digit_char = digit_to_ascii(dig_q);
  assign last_digit = last_q;

  a_no_push_while_emitting: assert property (@(posedge clk) disable iff (rst)
    push.en |-> !emitting)
    else $error("digit written while emitting");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && (cnt == CW'(1))) |=> (!emitting && last_digit))
    else $error("final digit not marked");

endmodule
